// File: sv/rsi_pkg.sv
package rsi_pkg;

   localparam int COORD_W = 16;
   localparam int RADIUS_W = 15;
   localparam int A_W = 32;
   localparam int H_W = 35;
   localparam int DISC_W = 67;
   localparam int ROOT_W = 34;
   localparam int RAD_W = 2 * ROOT_W;
   localparam int NUM_W = 36;
   localparam int ABS_W = NUM_W - 1;
   localparam int T_FRAC_BITS = 16;
   localparam int QUO_W = 31;
   localparam int T_W = 32;

   localparam logic [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
   localparam logic [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};

   // Side data that travels with the discriminant through the square root.
   typedef struct packed {
      logic signed [H_W-1:0] h;
      logic [A_W-1:0] a;
      logic miss;
   } rsi_meta_type;

   // Side data that travels with one division lane.
   typedef struct packed {
      logic [ABS_W-1:0] num_abs;
      logic neg;
      logic sat;
      logic [A_W-1:0] a;
      logic miss;
   } rsi_dlane_type;

endpackage

// File: sv/rsi_quad.sv
module rsi_quad (
   input logic clock,
   input logic reset,
   input logic adv,
   input logic in_valid,
   input logic signed [15:0] origin_x,
   input logic signed [15:0] origin_y,
   input logic signed [15:0] origin_z,
   input logic signed [15:0] dir_x,
   input logic signed [15:0] dir_y,
   input logic signed [15:0] dir_z,
   input logic signed [15:0] center_x,
   input logic signed [15:0] center_y,
   input logic signed [15:0] center_z,
   input logic [14:0] radius,
   output logic out_valid,
   output logic [rsi_pkg::DISC_W-1:0] out_disc,
   output rsi_pkg::rsi_meta_type out_meta
);

   // Stage 1: offset from the sphere center.
   logic s1_valid_ff;
   logic signed [16:0] vx_ff, vy_ff, vz_ff;
   logic signed [15:0] dx_ff, dy_ff, dz_ff;
   logic [14:0] r_ff;

   // Stage 2: all elementary products.
   logic s2_valid_ff;
   logic [30:0] ddx_ff, ddy_ff, ddz_ff;
   logic signed [32:0] vdx_ff, vdy_ff, vdz_ff;
   logic [32:0] vvx_ff, vvy_ff, vvz_ff;
   logic [29:0] rr_ff;
   logic [30:0] ddx_in, ddy_in, ddz_in;
   logic signed [32:0] vdx_in, vdy_in, vdz_in;
   logic [32:0] vvx_in, vvy_in, vvz_in;
   logic signed [31:0] sqx, sqy, sqz;
   logic signed [33:0] vsx, vsy, vsz;

   // Stage 3: a, h and c.
   logic s3_valid_ff;
   logic [31:0] a3_ff;
   logic signed [34:0] h3_ff, c3_ff;

   // Stage 4: magnitudes split into partial products.
   logic s4_valid_ff;
   logic [31:0] a4_ff;
   logic signed [34:0] h4_ff;
   logic a_zero4_ff, c_neg4_ff;
   logic [33:0] p_hll_ff, p_hac00_ff, p_hac01_ff;
   logic [32:0] p_hlh_ff;
   logic [31:0] p_hhh_ff, p_ac10_ff, p_ac11_ff;
   logic [32:0] h_abs;
   logic [33:0] c_abs;

   // Stage 5: h*h and a*|c|.
   logic s5_valid_ff;
   logic [31:0] a5_ff;
   logic signed [34:0] h5_ff;
   logic a_zero5_ff, c_neg5_ff;
   logic [65:0] hsq_ff, ac_ff;

   // Stage 6: the reduced discriminant h*h - a*c.
   logic s6_valid_ff;
   logic [rsi_pkg::DISC_W-1:0] disc_ff;
   rsi_pkg::rsi_meta_type meta_ff;
   logic [rsi_pkg::DISC_W-1:0] sum6, diff6;

   always_comb begin
      sqx = dx_ff * dx_ff;
      sqy = dy_ff * dy_ff;
      sqz = dz_ff * dz_ff;
      ddx_in = sqx[30:0];
      ddy_in = sqy[30:0];
      ddz_in = sqz[30:0];
      vdx_in = vx_ff * dx_ff;
      vdy_in = vy_ff * dy_ff;
      vdz_in = vz_ff * dz_ff;
      vsx = vx_ff * vx_ff;
      vsy = vy_ff * vy_ff;
      vsz = vz_ff * vz_ff;
      vvx_in = vsx[32:0];
      vvy_in = vsy[32:0];
      vvz_in = vsz[32:0];
   end

   always_comb begin
      h_abs = 33'(h3_ff[34] ? -h3_ff : h3_ff);
      c_abs = 34'(c3_ff[34] ? -c3_ff : c3_ff);
   end

   always_comb begin
      sum6 = 67'(hsq_ff) + 67'(ac_ff);
      diff6 = 67'(hsq_ff) - 67'(ac_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vx_ff <= 17'(origin_x) - 17'(center_x);
         vy_ff <= 17'(origin_y) - 17'(center_y);
         vz_ff <= 17'(origin_z) - 17'(center_z);
         dx_ff <= dir_x;
         dy_ff <= dir_y;
         dz_ff <= dir_z;
         r_ff <= radius;

         ddx_ff <= ddx_in;
         ddy_ff <= ddy_in;
         ddz_ff <= ddz_in;
         vdx_ff <= vdx_in;
         vdy_ff <= vdy_in;
         vdz_ff <= vdz_in;
         vvx_ff <= vvx_in;
         vvy_ff <= vvy_in;
         vvz_ff <= vvz_in;
         rr_ff <= r_ff * r_ff;

         a3_ff <= 32'(ddx_ff) + 32'(ddy_ff) + 32'(ddz_ff);
         h3_ff <= 35'(vdx_ff) + 35'(vdy_ff) + 35'(vdz_ff);
         c3_ff <= $signed(35'(vvx_ff)) + $signed(35'(vvy_ff)) + $signed(35'(vvz_ff))
            - $signed(35'(rr_ff));

         a4_ff <= a3_ff;
         h4_ff <= h3_ff;
         a_zero4_ff <= (a3_ff == '0);
         c_neg4_ff <= c3_ff[34];
         p_hll_ff <= h_abs[16:0] * h_abs[16:0];
         p_hlh_ff <= h_abs[16:0] * h_abs[32:17];
         p_hhh_ff <= h_abs[32:17] * h_abs[32:17];
         p_hac00_ff <= a3_ff[16:0] * c_abs[16:0];
         p_hac01_ff <= a3_ff[16:0] * c_abs[33:17];
         p_ac10_ff <= a3_ff[31:17] * c_abs[16:0];
         p_ac11_ff <= a3_ff[31:17] * c_abs[33:17];

         a5_ff <= a4_ff;
         h5_ff <= h4_ff;
         a_zero5_ff <= a_zero4_ff;
         c_neg5_ff <= c_neg4_ff;
         hsq_ff <= 66'(p_hll_ff) + (66'(p_hlh_ff) << 18) + (66'(p_hhh_ff) << 34);
         ac_ff <= 66'(p_hac00_ff) + ((66'(p_hac01_ff) + 66'(p_ac10_ff)) << 17)
            + (66'(p_ac11_ff) << 34);

         // A positive c larger than h*h/a leaves a negative discriminant.
         disc_ff <= c_neg5_ff ? sum6 : diff6;
         meta_ff.h <= h5_ff;
         meta_ff.a <= a5_ff;
         meta_ff.miss <= a_zero5_ff || (!c_neg5_ff && diff6[rsi_pkg::DISC_W-1]);
      end
   end

   assign out_valid = s6_valid_ff;
   assign out_disc = disc_ff;
   assign out_meta = meta_ff;

endmodule

// File: sv/rsi_sqrt.sv
module rsi_sqrt (
   input logic clock,
   input logic reset,
   input logic adv,
   input logic in_valid,
   input logic [rsi_pkg::DISC_W-1:0] in_disc,
   input rsi_pkg::rsi_meta_type in_meta,
   output logic out_valid,
   output logic [rsi_pkg::ROOT_W-1:0] out_root,
   output rsi_pkg::rsi_meta_type out_meta
);

   localparam int N = rsi_pkg::ROOT_W;

   logic valid_ff [N];
   logic [rsi_pkg::DISC_W-1:0] rem_ff [N];
   logic [N-1:0] root_ff [N];
   rsi_pkg::rsi_meta_type meta_ff [N];

   // One result bit per stage, from the top bit down.
   for (genvar g = 0; g < N; g++) begin : g_stage
      localparam int K = N - 1 - g;
      logic src_valid;
      logic [rsi_pkg::DISC_W-1:0] src_rem;
      logic [N-1:0] src_root;
      rsi_pkg::rsi_meta_type src_meta;
      logic [rsi_pkg::RAD_W-1:0] trial;
      logic take;

      if (g == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem = in_disc;
         assign src_root = '0;
         assign src_meta = in_meta;
      end else begin : g_next
         assign src_valid = valid_ff[g-1];
         assign src_rem = rem_ff[g-1];
         assign src_root = root_ff[g-1];
         assign src_meta = meta_ff[g-1];
      end

      // (root + 2^K)^2 - root^2, with root holding only bits above K.
      assign trial = (rsi_pkg::RAD_W'(src_root) << (K + 1))
         | (rsi_pkg::RAD_W'(1) << (2 * K));
      assign take = rsi_pkg::RAD_W'(src_rem) >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (adv) begin
            valid_ff[g] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[g] <= take ? rsi_pkg::DISC_W'(rsi_pkg::RAD_W'(src_rem) - trial) : src_rem;
            root_ff[g] <= take ? (src_root | (N'(1) << K)) : src_root;
            meta_ff[g] <= src_meta;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root = root_ff[N-1];
   assign out_meta = meta_ff[N-1];

endmodule

// File: sv/rsi_div.sv
module rsi_div (
   input logic clock,
   input logic reset,
   input logic adv,
   input logic in_valid,
   input logic signed [rsi_pkg::NUM_W-1:0] in_num,
   input logic [rsi_pkg::A_W-1:0] in_a,
   input logic in_miss,
   output logic out_valid,
   output logic out_hit,
   output logic [rsi_pkg::T_W-1:0] out_root
);

   localparam int N = rsi_pkg::QUO_W;
   localparam int CMP_W = rsi_pkg::A_W + N - rsi_pkg::T_FRAC_BITS;

   logic e_valid_ff;
   rsi_pkg::rsi_dlane_type e_ff;
   logic [rsi_pkg::ABS_W-1:0] num_abs;

   logic valid_ff [N];
   logic [rsi_pkg::A_W-1:0] rem_ff [N];
   logic [N-1:0] quo_ff [N];
   rsi_pkg::rsi_dlane_type lane_ff [N];
   logic [rsi_pkg::T_W-1:0] quo_ext;

   assign num_abs = rsi_pkg::ABS_W'(in_num[rsi_pkg::NUM_W-1] ? -in_num : in_num);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= in_valid;
      end
   end

   // A quotient of 2^31 or more in magnitude saturates, so only 31 bits are developed.
   always_ff @(posedge clock) begin
      if (adv) begin
         e_ff.num_abs <= num_abs;
         e_ff.neg <= in_num[rsi_pkg::NUM_W-1];
         e_ff.sat <= CMP_W'(num_abs) >= (CMP_W'(in_a) << (N - rsi_pkg::T_FRAC_BITS));
         e_ff.a <= in_a;
         e_ff.miss <= in_miss;
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_stage
      localparam int I = N - 1 - g;
      logic src_valid;
      rsi_pkg::rsi_dlane_type src_lane;
      logic [rsi_pkg::A_W-1:0] src_rem;
      logic [N-1:0] src_quo;
      logic dvd_bit;
      logic [rsi_pkg::A_W:0] shifted;
      logic take;

      if (g == 0) begin : g_first
         assign src_valid = e_valid_ff;
         assign src_lane = e_ff;
         assign src_rem = rsi_pkg::A_W'(e_ff.num_abs[rsi_pkg::ABS_W-1:N-rsi_pkg::T_FRAC_BITS]);
         assign src_quo = '0;
      end else begin : g_next
         assign src_valid = valid_ff[g-1];
         assign src_lane = lane_ff[g-1];
         assign src_rem = rem_ff[g-1];
         assign src_quo = quo_ff[g-1];
      end

      // The dividend is |num| shifted up by the fraction width.
      if (I >= rsi_pkg::T_FRAC_BITS) begin : g_bit
         assign dvd_bit = src_lane.num_abs[I-rsi_pkg::T_FRAC_BITS];
      end else begin : g_zero
         assign dvd_bit = 1'b0;
      end

      assign shifted = {src_rem, dvd_bit};
      assign take = shifted >= {1'b0, src_lane.a};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (adv) begin
            valid_ff[g] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[g] <= take ? rsi_pkg::A_W'(shifted - {1'b0, src_lane.a})
               : shifted[rsi_pkg::A_W-1:0];
            quo_ff[g] <= {src_quo[N-2:0], take};
            lane_ff[g] <= src_lane;
         end
      end
   end

   assign quo_ext = rsi_pkg::T_W'(quo_ff[N-1]);

   always_comb begin
      if (lane_ff[N-1].sat) begin
         out_root = lane_ff[N-1].neg ? rsi_pkg::T_MIN : rsi_pkg::T_MAX;
      end else begin
         out_root = lane_ff[N-1].neg ? -quo_ext : quo_ext;
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_hit = !lane_ff[N-1].miss;

endmodule

// File: sv/ray_sphere_intersect.sv
// Ray-sphere intersection, fully pipelined.
// Throughput: one transaction per cycle; the 34-stage square root and the two
// 31-stage dividers each resolve one bit per stage, and any stall freezes all stages.
// Reset (synchronous, active high) clears every valid bit; no clearing pass is needed.
module ray_sphere_intersect (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
   // center_x, center_y, center_z, radius, one zero pad bit
   input logic [159:0] req_tdata,
   output logic rsp_tvalid,
   input logic rsp_tready,
   // t_near, t_far
   output logic [63:0] rsp_tdata,
   // hit
   output logic [0:0] rsp_tuser
);

   logic adv;
   logic q_valid;
   logic [rsi_pkg::DISC_W-1:0] q_disc;
   rsi_pkg::rsi_meta_type q_meta;
   logic r_valid;
   logic [rsi_pkg::ROOT_W-1:0] r_root;
   rsi_pkg::rsi_meta_type r_meta;

   logic n_valid_ff;
   logic signed [rsi_pkg::NUM_W-1:0] num_near_ff, num_far_ff;
   logic [rsi_pkg::A_W-1:0] n_a_ff;
   logic n_miss_ff;

   logic near_valid, far_valid, near_hit, far_hit;
   logic [rsi_pkg::T_W-1:0] near_root, far_root;

   logic rsp_valid_ff, hit_ff;
   logic [rsi_pkg::T_W-1:0] t_near_ff, t_far_ff;

   // The whole pipeline moves unless a finished result is held back.
   assign adv = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   rsi_quad u_quad (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .in_valid(req_tvalid),
      .origin_x(req_tdata[15:0]),
      .origin_y(req_tdata[31:16]),
      .origin_z(req_tdata[47:32]),
      .dir_x(req_tdata[63:48]),
      .dir_y(req_tdata[79:64]),
      .dir_z(req_tdata[95:80]),
      .center_x(req_tdata[111:96]),
      .center_y(req_tdata[127:112]),
      .center_z(req_tdata[143:128]),
      .radius(req_tdata[158:144]),
      .out_valid(q_valid),
      .out_disc(q_disc),
      .out_meta(q_meta)
   );

   rsi_sqrt u_sqrt (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .in_valid(q_valid),
      .in_disc(q_disc),
      .in_meta(q_meta),
      .out_valid(r_valid),
      .out_root(r_root),
      .out_meta(r_meta)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         n_valid_ff <= 1'b0;
      end else if (adv) begin
         n_valid_ff <= r_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_near_ff <= -rsi_pkg::NUM_W'(r_meta.h) - $signed(rsi_pkg::NUM_W'(r_root));
         num_far_ff <= -rsi_pkg::NUM_W'(r_meta.h) + $signed(rsi_pkg::NUM_W'(r_root));
         n_a_ff <= r_meta.a;
         n_miss_ff <= r_meta.miss;
      end
   end

   rsi_div u_div_near (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .in_valid(n_valid_ff),
      .in_num(num_near_ff),
      .in_a(n_a_ff),
      .in_miss(n_miss_ff),
      .out_valid(near_valid),
      .out_hit(near_hit),
      .out_root(near_root)
   );

   rsi_div u_div_far (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .in_valid(n_valid_ff),
      .in_num(num_far_ff),
      .in_a(n_a_ff),
      .in_miss(n_miss_ff),
      .out_valid(far_valid),
      .out_hit(far_hit),
      .out_root(far_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= near_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff <= near_hit;
         t_near_ff <= near_hit ? near_root : '0;
         t_far_ff <= near_hit ? far_root : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {t_far_ff, t_near_ff};
   assign rsp_tuser = hit_ff;

`ifndef NO_ASSERTIONS
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (near_valid == far_valid) && (!near_valid || near_hit == far_hit))
      else $error("division lanes out of step");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !hit_ff |-> (t_near_ff == '0) && (t_far_ff == '0))
      else $error("miss with nonzero roots");

   a_root_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && hit_ff |-> $signed(t_near_ff) <= $signed(t_far_ff))
      else $error("near root above far root");
`endif

endmodule

// File: tb/sv/ray_sphere_intersect_tb.sv
`timescale 1ns / 1ps

module ray_sphere_intersect_tb;

   typedef struct {
      logic hit;
      logic signed [31:0] t_near;
      logic signed [31:0] t_far;
   } hit_result_type;

   // Keeps the expected intersections in order and compares arriving responses.
   class intersect_board;
      hit_result_type pending[$];
      int mismatches;
      int checked;
      int misses_seen;
      int hits_seen;

      function new();
         mismatches = 0;
         checked = 0;
         misses_seen = 0;
         hits_seen = 0;
      endfunction

      static function logic signed [31:0] clamp_root(logic signed [67:0] num,
                                                    logic signed [67:0] a);
         logic signed [67:0] q;
         q = (num <<< 16) / a;
         if (q > 68'sd2147483647) q = 68'sd2147483647;
         if (q < -68'sd2147483648) q = -68'sd2147483648;
         return q[31:0];
      endfunction

      // The discriminant stays below 2^67, so the root has at most 34 bits and
      // every trial square fits in 68 bits.
      static function logic [67:0] floor_sqrt(logic [67:0] v);
         logic [67:0] root;
         logic [67:0] cand;
         root = 0;
         for (int k = 33; k >= 0; k--) begin
            cand = root | (68'd1 << k);
            if (cand * cand <= v) root = cand;
         end
         return root;
      endfunction

      function void note_ray(logic [159:0] d);
         logic signed [67:0] vx, vy, vz, dx, dy, dz, r, a, h, c, disc, s;
         hit_result_type e;
         vx = $signed(d[15:0]) - $signed(d[111:96]);
         vy = $signed(d[31:16]) - $signed(d[127:112]);
         vz = $signed(d[47:32]) - $signed(d[143:128]);
         dx = $signed(d[63:48]);
         dy = $signed(d[79:64]);
         dz = $signed(d[95:80]);
         r = {53'd0, d[158:144]};
         a = dx * dx + dy * dy + dz * dz;
         h = vx * dx + vy * dy + vz * dz;
         c = vx * vx + vy * vy + vz * vz - r * r;
         disc = h * h - a * c;
         e.hit = 0;
         e.t_near = 0;
         e.t_far = 0;
         if (a != 0 && disc >= 0) begin
            s = floor_sqrt(disc);
            e.hit = 1;
            e.t_near = clamp_root(-h - s, a);
            e.t_far = clamp_root(-h + s, a);
         end
         pending.push_back(e);
      endfunction

      function void check_response(logic [63:0] d, logic u);
         hit_result_type e;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h hit %b", d, u);
            return;
         end
         e = pending.pop_front();
         if (e.hit) hits_seen++; else misses_seen++;
         if (u !== e.hit || d[31:0] !== e.t_near || d[63:32] !== e.t_far) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected hit %b near %h far %h, got hit %b near %h far %h",
                        e.hit, e.t_near, e.t_far, u, d[31:0], d[63:32]);
         end
      endfunction
   endclass

   localparam int LATENCY = 74;
   localparam int STALL_LIMIT = 5000;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [159:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [63:0] rsp_tdata;
   logic [0:0] rsp_tuser;

   intersect_board board;
   bit calm_phase;
   bit hold_rsp;
   int idle_cycles;
   int rays_sent;

   ray_sphere_intersect dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic logic [159:0] pack_ray(logic [15:0] ox, logic [15:0] oy,
                                             logic [15:0] oz, logic [15:0] dx,
                                             logic [15:0] dy, logic [15:0] dz,
                                             logic [15:0] cx, logic [15:0] cy,
                                             logic [15:0] cz, logic [14:0] r);
      return {1'b0, r, cz, cy, cx, dz, dy, dx, oz, oy, ox};
   endfunction

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($signed($urandom_range(0, 1024)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly rays aimed near the sphere so that hits dominate, with wild rays mixed in.
   function automatic logic [159:0] random_ray();
      logic [15:0] cx, cy, cz, ox, oy, oz;
      logic [14:0] r;
      if ($urandom_range(0, 3) == 0)
         return pack_ray(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), 15'($urandom));
      cx = 16'($urandom_range(0, 8000)) - 16'd4000;
      cy = 16'($urandom_range(0, 8000)) - 16'd4000;
      cz = 16'($urandom_range(0, 8000)) - 16'd4000;
      ox = 16'($urandom_range(0, 8000)) - 16'd4000;
      oy = 16'($urandom_range(0, 8000)) - 16'd4000;
      oz = 16'($urandom_range(0, 8000)) - 16'd4000;
      r = 15'($urandom_range(0, 6000));
      return pack_ray(ox, oy, oz, cx - ox + 16'($urandom_range(0, 400)) - 16'd200,
                      cy - oy + 16'($urandom_range(0, 400)) - 16'd200,
                      cz - oz, cx, cy, cz, r);
   endfunction

   // Entered at a falling edge; valid drops only while the sender idles.
   task automatic send_ray(logic [159:0] d);
      while (!calm_phase && $urandom_range(0, 99) < 28) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_ray(d);
      rays_sent++;
      @(negedge clock);
   endtask

   // Receiver side: random stalls, or a long hold while the sender keeps pushing.
   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_tready <= 0;
      else rsp_tready <= calm_phase || ($urandom_range(0, 99) >= 28);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata, rsp_tuser[0]);
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("ray_sphere_intersect_tb: done, errors");
         $finish;
      end
   end

   initial begin
      hold_rsp = 0;
      for (int k = 0; k < 3; k++) begin
         wait (rays_sent >= 300 + k * 300);
         @(negedge clock);
         hold_rsp = 1;
         repeat (200) @(negedge clock);
         hold_rsp = 0;
      end
   end

   initial begin
      board = new();
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      rsp_tready = 0;
      calm_phase = 0;
      rays_sent = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: zero direction, clear hit, clear miss, point sphere, extremes, saturation.
      send_ray(pack_ray(0, 0, 0, 0, 0, 0, 0, 0, 16'h0400, 15'h0100));
      send_ray(pack_ray(0, 0, 0, 0, 0, 16'h0100, 0, 0, 16'h0a00, 15'h0100));
      send_ray(pack_ray(0, 0, 0, 16'h0100, 0, 0, 0, 16'h0a00, 0, 15'h0100));
      send_ray(pack_ray(0, 0, 0, 16'h0100, 0, 0, 16'h0500, 0, 0, 15'h0000));
      send_ray(pack_ray(0, 0, 0, 16'h0001, 0, 0, 16'h7fff, 0, 0, 15'h7fff));
      send_ray(pack_ray(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
                        16'h7fff, 16'h7fff, 16'h7fff, 15'h7fff));
      send_ray(pack_ray(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
                        16'h8000, 16'h8000, 16'h8000, 15'h7fff));
      send_ray(pack_ray(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                        16'hffff, 16'hffff, 16'hffff, 15'h7fff));
      send_ray(pack_ray(0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                        16'h7fff, 15'h0000));
      send_ray(pack_ray(16'h0100, 0, 0, 16'h0100, 0, 0, 16'h0100, 0, 0, 15'h0000));
      send_ray(pack_ray(0, 0, 0, 0, 16'h0001, 0, 0, 0, 0, 15'h7fff));
      send_ray(pack_ray(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                        16'h5555, 16'haaaa, 16'h5555, 15'h2aaa));

      for (int i = 0; i < 1300; i++) begin
         calm_phase = (i >= 900 && i < 1050);
         send_ray(random_ray());
      end
      calm_phase = 0;
      req_tvalid <= 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("Sent %0d rays: %0d hits and %0d misses checked, with random and long stalls.",
               rays_sent, board.hits_seen, board.misses_seen);
      if (board.mismatches == 0 && board.pending.size() == 0 && board.checked == rays_sent)
         $display("ray_sphere_intersect_tb: done, clean");
      else begin
         $display("%0d mismatches, %0d responses still outstanding",
                  board.mismatches, board.pending.size());
         $display("ray_sphere_intersect_tb: done, errors");
      end
      $finish;
   end

endmodule
